// ===== rtl/dsl_pkg.sv =====
// Shared types and constants for the dashed line stipple unit.
package dsl_pkg;

   localparam int SEG_W = 24;
   localparam int FRAC_W = 17;
   localparam int PHASE_W = 17;
   localparam int MOD_W = 25;
   localparam int CHUNK_W = 7;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW = 2;

   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
   localparam logic [CHUNK_W-1:0] MAX_PIECES = 7'd64;

   localparam logic [1:0] CSR_DASHED_MODE = 2'd0;
   localparam logic [1:0] CSR_DASH_ON_LEN = 2'd1;
   localparam logic [1:0] CSR_DASH_OFF_LEN = 2'd2;
   localparam logic [1:0] CSR_MAX_CHUNKS = 2'd3;

   typedef enum logic [2:0] {
      KIND_PASS  = 3'b001,
      KIND_DASH  = 3'b010,
      KIND_CLEAR = 3'b100
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic              first;
      logic [SEG_W-1:0]  seg_len;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } job_wr_type;

   typedef struct packed {
      logic        dashed_mode;
      logic [15:0] dash_on_len;
      logic [15:0] dash_off_len;
      logic [6:0]  max_chunks;
   } cfg_type;

endpackage

// ===== rtl/dsl_front.sv =====
// Front end: accepts segments and classifies them for the back end.
module dsl_front (
   input  logic                     dashed_mode,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [23:0]              req_seg_len_px,
   input  logic                     req_first_segment,
   input  logic                     fifo_full,
   output dsl_pkg::job_wr_type      wr
);

   logic seg_zero;

   assign seg_zero = (req_seg_len_px == '0);
   assign req_stall = fifo_full;

   always_comb begin
      wr.job.seg_len = req_seg_len_px;
      wr.job.first = req_first_segment;
      if (seg_zero) begin
         wr.job.kind = dsl_pkg::KIND_CLEAR;
      end else if (dashed_mode) begin
         wr.job.kind = dsl_pkg::KIND_DASH;
      end else begin
         wr.job.kind = dsl_pkg::KIND_PASS;
      end
      // A zero-length segment only matters when it clears the phase.
      wr.push = req_valid && !fifo_full && (!seg_zero || req_first_segment);
   end

endmodule

// ===== rtl/dsl_fifo.sv =====
// Short job queue between the front end and the back end.
module dsl_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  dsl_pkg::job_wr_type  wr,
   input  logic                 pop,
   output logic                 full,
   output logic                 empty,
   output dsl_pkg::job_type     rd_job
);

   dsl_pkg::job_type mem_ff [dsl_pkg::FIFO_DEPTH];
   logic [dsl_pkg::FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dsl_pkg::FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dsl_pkg::FIFO_AW:0]   count_ff, count_in;
   logic                        do_pop;

   assign full = (count_ff == (dsl_pkg::FIFO_AW+1)'(dsl_pkg::FIFO_DEPTH));
   assign empty = (count_ff == '0);
   assign rd_job = mem_ff[rd_ptr_ff];
   assign do_pop = pop && !empty;

   always_comb begin
      wr_ptr_in = wr.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (wr.push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!wr.push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.push) begin
         mem_ff[wr_ptr_ff] <= wr.job;
      end
   end

endmodule

// ===== rtl/dsl_frac_div.sv =====
// Bit-serial divider giving floor(pos * 65536 / seg) for pos no larger than seg.
module dsl_frac_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dsl_pkg::SEG_W-1:0]     pos,
   input  logic [dsl_pkg::SEG_W-1:0]     seg,
   output logic                          busy,
   output logic [dsl_pkg::FRAC_W-1:0]    quot
);

   logic                         busy_ff, busy_in;
   logic [dsl_pkg::SEG_W-1:0]    r_ff, r_in;
   logic [dsl_pkg::SEG_W-1:0]    d_ff, d_in;
   logic [dsl_pkg::FRAC_W-1:0]   q_ff, q_in;
   logic [4:0]                   cnt_ff, cnt_in;
   logic [dsl_pkg::SEG_W:0]      trial;
   logic                         take;
   logic                         first_bit;

   assign busy = busy_ff;
   assign quot = q_ff;

   always_comb begin
      trial = {r_ff, 1'b0};
      take = (trial >= {1'b0, d_ff});
      first_bit = (pos >= seg);
      busy_in = busy_ff;
      r_in = r_ff;
      d_in = d_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         d_in = seg;
         r_in = first_bit ? pos - seg : pos;
         q_in = {{(dsl_pkg::FRAC_W-1){1'b0}}, first_bit};
         cnt_in = 5'(dsl_pkg::FRAC_W - 1);
      end else if (busy_ff) begin
         r_in = take ? dsl_pkg::SEG_W'(trial - {1'b0, d_ff}) : dsl_pkg::SEG_W'(trial);
         q_in = {q_ff[dsl_pkg::FRAC_W-2:0], take};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      d_ff <= d_in;
      q_ff <= q_in;
   end

endmodule

// ===== rtl/dsl_back.sv =====
// Back end: emits pass segments whole; walks dashed ones and emits their on pieces.
module dsl_back #(
   parameter int FRAC_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  dsl_pkg::cfg_type            cfg,
   input  logic                        fifo_empty,
   input  dsl_pkg::job_type            job,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [16:0]                 rsp_start_frac,
   output logic [16:0]                 rsp_end_frac,
   output logic                        rsp_last_piece
);

   localparam int PW = dsl_pkg::PHASE_W;
   localparam int SW = dsl_pkg::SEG_W;
   localparam int MW = dsl_pkg::MOD_W;
   localparam int FW = dsl_pkg::FRAC_W;
   localparam int CW = dsl_pkg::CHUNK_W;
   localparam logic [PW-1:0] ONE_PX = PW'(1) << FRAC_BITS;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHUNK = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_ADV   = 6'b001000,
      ST_MOD   = 6'b010000,
      ST_FIN   = 6'b100000
   } state_type;

   state_type     state_ff, state_in;
   logic [PW-1:0] phase_ff, phase_in;
   logic [PW-1:0] work_ff, work_in;
   logic [SW-1:0] seg_ff, seg_in;
   logic [SW-1:0] cursor_ff, cursor_in;
   logic [SW-1:0] next_ff, next_in;
   logic [SW-1:0] step_ff, step_in;
   logic          on_now_ff, on_now_in;
   logic [CW-1:0] chunks_ff, chunks_in;
   logic [FW-1:0] u_cur_ff, u_cur_in;
   logic          pend_valid_ff, pend_valid_in;
   logic [FW-1:0] pend_start_ff, pend_start_in;
   logic [FW-1:0] pend_end_ff, pend_end_in;
   logic [MW-1:0] mod_x_ff, mod_x_in;
   logic [PW-1:0] mod_r_ff, mod_r_in;
   logic [4:0]    mod_cnt_ff, mod_cnt_in;
   logic          mod_final_ff, mod_final_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0] rsp_start_ff, rsp_start_in;
   logic [FW-1:0] rsp_end_ff, rsp_end_in;
   logic          rsp_last_ff, rsp_last_in;

   logic [PW-1:0] on_len;
   logic [PW-1:0] period;
   logic [CW-1:0] limit;
   logic [SW-1:0] remain;
   logic          on_now;
   logic [PW-1:0] rem_raw;
   logic [PW-1:0] rem;
   logic [SW-1:0] step;
   logic          walking;
   logic [MW-1:0] red_x;
   logic [MW-1:0] red_diff;
   logic          red_ge;
   logic          red_slow;
   logic [PW-1:0] red_val;
   logic [PW:0]   mod_t;
   logic [PW:0]   mod_t_sub;
   logic          out_free;
   logic          div_start;
   logic          div_busy;
   logic [FW-1:0] div_q;
   logic          emit_new;

   dsl_frac_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .pos   (next_in),
      .seg   (seg_ff),
      .busy  (div_busy),
      .quot  (div_q)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_start_frac = rsp_start_ff;
   assign rsp_end_frac = rsp_end_ff;
   assign rsp_last_piece = rsp_last_ff;

   always_comb begin
      on_len = {1'b0, cfg.dash_on_len};
      period = PW'({1'b0, cfg.dash_on_len} + {1'b0, cfg.dash_off_len});
      limit = (cfg.max_chunks > dsl_pkg::MAX_PIECES) ? dsl_pkg::MAX_PIECES : cfg.max_chunks;
      remain = seg_ff - cursor_ff;
      walking = (cursor_ff < seg_ff) && (chunks_ff < limit);
      on_now = (work_ff < on_len);
      if (on_now) begin
         rem_raw = on_len - work_ff;
      end else if (period > work_ff) begin
         rem_raw = period - work_ff;
      end else begin
         rem_raw = '0;
      end
      rem = (rem_raw == '0) ? ONE_PX : rem_raw;
      step = (SW'(rem) < remain) ? SW'(rem) : remain;

      // Fold the phase back into the period: at most one subtraction here,
      // otherwise the serial remainder loop takes over.
      red_x = (state_ff == ST_ADV) ? MW'(work_ff) + MW'(step_ff)
                                   : MW'(work_ff) + MW'(remain);
      red_ge = (red_x >= MW'(period));
      red_diff = red_x - MW'(period);
      red_slow = 1'b0;
      if (!red_ge) begin
         red_val = PW'(red_x);
      end else if (period == '0) begin
         red_val = '0;
      end else if (red_diff < MW'(period)) begin
         red_val = PW'(red_diff);
      end else begin
         red_val = work_ff;
         red_slow = 1'b1;
      end

      mod_t = {mod_r_ff, mod_x_ff[MW-1]};
      mod_t_sub = mod_t - {1'b0, period};
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      work_in = work_ff;
      seg_in = seg_ff;
      cursor_in = cursor_ff;
      next_in = next_ff;
      step_in = step_ff;
      on_now_in = on_now_ff;
      chunks_in = chunks_ff;
      u_cur_in = u_cur_ff;
      pend_valid_in = pend_valid_ff;
      pend_start_in = pend_start_ff;
      pend_end_in = pend_end_ff;
      mod_x_in = mod_x_ff;
      mod_r_in = mod_r_ff;
      mod_cnt_in = mod_cnt_ff;
      mod_final_in = mod_final_ff;
      out_free = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_start_in = rsp_start_ff;
      rsp_end_in = rsp_end_ff;
      rsp_last_in = rsp_last_ff;
      pop = 1'b0;
      div_start = 1'b0;
      emit_new = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (!fifo_empty && (job.kind != dsl_pkg::KIND_PASS || out_free)) begin
               pop = 1'b1;
               if (job.first) begin
                  phase_in = '0;
               end
               case (job.kind)
                  dsl_pkg::KIND_PASS: begin
                     rsp_valid_in = 1'b1;
                     rsp_start_in = '0;
                     rsp_end_in = dsl_pkg::FRAC_ONE;
                     rsp_last_in = 1'b1;
                  end
                  dsl_pkg::KIND_DASH: begin
                     work_in = job.first ? '0 : phase_ff;
                     seg_in = job.seg_len;
                     cursor_in = '0;
                     chunks_in = '0;
                     u_cur_in = '0;
                     pend_valid_in = 1'b0;
                     state_in = ST_CHUNK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_CHUNK: begin
            if (walking) begin
               next_in = cursor_ff + step;
               step_in = step;
               on_now_in = on_now;
               div_start = 1'b1;
               state_in = ST_DIV;
            end else if (cursor_ff < seg_ff) begin
               if (red_slow) begin
                  mod_x_in = red_x;
                  mod_r_in = '0;
                  mod_cnt_in = 5'(MW);
                  mod_final_in = 1'b1;
                  state_in = ST_MOD;
               end else begin
                  work_in = red_val;
                  state_in = ST_FIN;
               end
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               emit_new = on_now_ff && (div_q > u_cur_ff);
               if (!(emit_new && pend_valid_ff && !out_free)) begin
                  if (emit_new) begin
                     if (pend_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_start_in = pend_start_ff;
                        rsp_end_in = pend_end_ff;
                        rsp_last_in = 1'b0;
                     end
                     pend_valid_in = 1'b1;
                     pend_start_in = u_cur_ff;
                     pend_end_in = div_q;
                  end
                  u_cur_in = div_q;
                  state_in = ST_ADV;
               end
            end
         end
         ST_ADV: begin
            cursor_in = next_ff;
            chunks_in = chunks_ff + 1'b1;
            if (red_slow) begin
               mod_x_in = red_x;
               mod_r_in = '0;
               mod_cnt_in = 5'(MW);
               mod_final_in = 1'b0;
               state_in = ST_MOD;
            end else begin
               work_in = red_val;
               state_in = ST_CHUNK;
            end
         end
         ST_MOD: begin
            mod_r_in = (mod_t >= {1'b0, period}) ? PW'(mod_t_sub) : PW'(mod_t);
            mod_x_in = {mod_x_ff[MW-2:0], 1'b0};
            mod_cnt_in = mod_cnt_ff - 1'b1;
            if (mod_cnt_ff == 5'd1) begin
               work_in = mod_r_in;
               state_in = mod_final_ff ? ST_FIN : ST_CHUNK;
            end
         end
         ST_FIN: begin
            if (!pend_valid_ff) begin
               phase_in = work_ff;
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_start_in = pend_start_ff;
               rsp_end_in = pend_end_ff;
               rsp_last_in = 1'b1;
               pend_valid_in = 1'b0;
               phase_in = work_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chunks_ff <= '0;
         mod_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         chunks_ff <= chunks_in;
         mod_cnt_ff <= mod_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      seg_ff <= seg_in;
      cursor_ff <= cursor_in;
      next_ff <= next_in;
      step_ff <= step_in;
      on_now_ff <= on_now_in;
      u_cur_ff <= u_cur_in;
      pend_start_ff <= pend_start_in;
      pend_end_ff <= pend_end_in;
      mod_x_ff <= mod_x_in;
      mod_r_ff <= mod_r_in;
      mod_final_ff <= mod_final_in;
      rsp_start_ff <= rsp_start_in;
      rsp_end_ff <= rsp_end_in;
      rsp_last_ff <= rsp_last_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_start_ff < rsp_end_ff))
      else $error("Emitted piece is empty or reversed.");

   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("Divider restarted while busy.");

   assert property (@(posedge clock) disable iff (reset)
      chunks_ff <= dsl_pkg::MAX_PIECES)
      else $error("Chunk count ran past its limit.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD) |-> (period != '0))
      else $error("Remainder loop entered with a zero period.");

endmodule

// ===== rtl/dashed_line_stipple_unit.sv =====
// A whole-segment pass beat goes via the queue and output register; a skipped segment yields none.
// Each chunk of a dashed segment passes the CHUNK, DIV and ADV states, using the 17-step serial divider.
// A phase that lies far past the period adds a serial remainder pass.
// The job queue holds up to 4 segments, so input beats keep flowing while a segment is walked.
// Synchronous reset restores register defaults, clears the dash phase and empties the queue.
module dashed_line_stipple_unit #(
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [23:0] req_seg_len_px,
   input  logic        req_first_segment,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [16:0] rsp_start_frac,
   output logic [16:0] rsp_end_frac,
   output logic        rsp_last_piece,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   dsl_pkg::cfg_type    cfg_ff, cfg_in;
   dsl_pkg::job_wr_type wr;
   dsl_pkg::job_type    rd_job;
   logic                fifo_full;
   logic                fifo_empty;
   logic                pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            dsl_pkg::CSR_DASHED_MODE: cfg_in.dashed_mode = csr_data[0];
            dsl_pkg::CSR_DASH_ON_LEN: cfg_in.dash_on_len = csr_data;
            dsl_pkg::CSR_DASH_OFF_LEN: cfg_in.dash_off_len = csr_data;
            dsl_pkg::CSR_MAX_CHUNKS: cfg_in.max_chunks = csr_data[6:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dashed_mode <= 1'b0;
         cfg_ff.dash_on_len <= 16'd2048;
         cfg_ff.dash_off_len <= 16'd1536;
         cfg_ff.max_chunks <= 7'd64;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dsl_front u_front (
      .dashed_mode       (cfg_ff.dashed_mode),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_seg_len_px    (req_seg_len_px),
      .req_first_segment (req_first_segment),
      .fifo_full         (fifo_full),
      .wr                (wr)
   );

   dsl_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .pop    (pop),
      .full   (fifo_full),
      .empty  (fifo_empty),
      .rd_job (rd_job)
   );

   dsl_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .fifo_empty     (fifo_empty),
      .job            (rd_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_start_frac (rsp_start_frac),
      .rsp_end_frac   (rsp_end_frac),
      .rsp_last_piece (rsp_last_piece)
   );

endmodule
